@@ hdl/g3b_pkg.sv @@
// ----------------------------------------------------------------------------
// g3b_pkg
// Shared constants and types for the 3D grid multi-source BFS unit.
// ----------------------------------------------------------------------------
`default_nettype none
package g3b_pkg;
   localparam int unsigned MAX_COLS_DEF   = 32;
   localparam int unsigned MAX_ROWS_DEF   = 32;
   localparam int unsigned MAX_LAYERS_DEF = 32;
   localparam int unsigned DIM_W  = 6;
   localparam int unsigned DIST_W = 8;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_COLS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYERS = 2'd2;

   localparam logic [1:0] KIND_OPEN   = 2'b00;
   localparam logic [1:0] KIND_SOURCE = 2'b01;

   typedef enum logic [7:0] {
      ST_LOAD  = 8'b0000_0001,
      ST_FILL  = 8'b0000_0010,
      ST_POP   = 8'b0000_0100,
      ST_CUR   = 8'b0000_1000,
      ST_NBR   = 8'b0001_0000,
      ST_CHK   = 8'b0010_0000,
      ST_SCAN  = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;
endpackage
`default_nettype wire

@@ hdl/grid3d_multisource_bfs_days_unit.sv @@
// ----------------------------------------------------------------------------
// grid3d_multisource_bfs_days_unit
// Loads a 3D grid, floods distances from all sources, reports the maximum or flags an unreachable cell.
// ----------------------------------------------------------------------------
// Sequence: each loaded cell is written; after the last cell, each unloaded
//   cell is filled as reached, then each queued cell is popped and read and
//   its in-grid neighbors checked in turn until the queue is found empty, and
//   a final scan reads every cell for the maximum distance.
// Throughput: one cell word per cycle during the load.
// Reset: synchronous, active high; clears control state and the dimensions
//   to 32. Memory contents are not cleared; every cell is written first.
`default_nettype none
module grid3d_multisource_bfs_days_unit
   import g3b_pkg::*;
#(
   parameter int unsigned MAX_COLS   = MAX_COLS_DEF,
   parameter int unsigned MAX_ROWS   = MAX_ROWS_DEF,
   parameter int unsigned MAX_LAYERS = MAX_LAYERS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]     csr_data,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [7:0]           req_tdata,   // [1:0] cell_kind
   input  wire logic                 req_tlast,   // last_cell
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [7:0]                rsp_tdata,   // [6:0] max_distance
   output logic                      rsp_tuser    // unreachable
);
   localparam int unsigned CW = $clog2(MAX_COLS);
   localparam int unsigned RW = $clog2(MAX_ROWS);
   localparam int unsigned LW = $clog2(MAX_LAYERS);
   localparam int unsigned AW = CW + RW + LW;
   localparam int unsigned DEPTH = 2**AW;
   localparam int unsigned QW = AW + 1;

   // cell memory: bit 8 reached, [7:0] distance; addressed {layer,row,col}
   logic [DIST_W:0]  cell_mem [DEPTH];
   logic [AW-1:0]    queue_mem [DEPTH];
   logic [DIST_W:0]  cell_rd_ff;
   logic [AW-1:0]    queue_rd_ff;

   logic             cell_we;
   logic [AW-1:0]    cell_wa, cell_ra;
   logic [DIST_W:0]  cell_wd;
   logic             q_we;
   logic [AW-1:0]    q_wd;

   logic [DIM_W-1:0] cols_ff, rows_ff, lays_ff;
   state_type        state_ff, state_in;
   logic [CW-1:0]    c_ff, c_in;
   logic [RW-1:0]    r_ff, r_in;
   logic [LW-1:0]    l_ff, l_in;
   logic             ldone_ff, ldone_in;
   logic [QW-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]    cc_ff, cc_in;
   logic [RW-1:0]    cr_ff, cr_in;
   logic [LW-1:0]    cl_ff, cl_in;
   logic [DIST_W-1:0] cd_ff, cd_in;
   logic [2:0]       dir_ff, dir_in;
   logic [AW-1:0]    na_ff, na_in;
   logic             unr_ff, unr_in;
   logic [DIST_W-1:0] best_ff, best_in;
   logic [6:0]       out_d_ff, out_d_in;
   logic             out_u_ff, out_u_in;

   logic [CW:0] nc;
   logic [RW:0] nr;
   logic [LW:0] nl;

   always_comb begin
      nc = (cols_ff == '0) ? (CW+1)'(1) :
           ({2'b0, cols_ff} > 8'(MAX_COLS)) ? (CW+1)'(MAX_COLS) : (CW+1)'(cols_ff);
      nr = (rows_ff == '0) ? (RW+1)'(1) :
           ({2'b0, rows_ff} > 8'(MAX_ROWS)) ? (RW+1)'(MAX_ROWS) : (RW+1)'(rows_ff);
      nl = (lays_ff == '0) ? (LW+1)'(1) :
           ({2'b0, lays_ff} > 8'(MAX_LAYERS)) ? (LW+1)'(MAX_LAYERS) : (LW+1)'(lays_ff);
   end

   logic last_c, last_r, last_l, at_end;
   assign last_c = ({1'b0, c_ff} == nc - 1'b1);
   assign last_r = ({1'b0, r_ff} == nr - 1'b1);
   assign last_l = ({1'b0, l_ff} == nl - 1'b1);
   assign at_end = last_c & last_r & last_l;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {1'b0, out_d_ff};
   assign rsp_tuser  = out_u_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= DIM_W'(32);
         rows_ff <= DIM_W'(32);
         lays_ff <= DIM_W'(32);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_COLS:   cols_ff <= csr_data;
            CSR_ROWS:   rows_ff <= csr_data;
            CSR_LAYERS: lays_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cell_we) cell_mem[cell_wa] <= cell_wd;
      cell_rd_ff <= cell_mem[cell_ra];
   end

   always_ff @(posedge clock) begin
      if (q_we) queue_mem[tail_ff[AW-1:0]] <= q_wd;
      queue_rd_ff <= queue_mem[head_ff[AW-1:0]];
   end

   // neighbor coordinate for current direction
   logic          nvalid;
   logic [CW-1:0] ncol;
   logic [RW-1:0] nrow;
   logic [LW-1:0] nlay;
   always_comb begin
      ncol = cc_ff; nrow = cr_ff; nlay = cl_ff; nvalid = 1'b0;
      case (dir_ff)
         3'd0: begin nrow = cr_ff + 1'b1; nvalid = ({1'b0, cr_ff} + 1'b1) < nr; end
         3'd1: begin ncol = cc_ff + 1'b1; nvalid = ({1'b0, cc_ff} + 1'b1) < nc; end
         3'd2: begin nlay = cl_ff + 1'b1; nvalid = ({1'b0, cl_ff} + 1'b1) < nl; end
         3'd3: begin nrow = cr_ff - 1'b1; nvalid = (cr_ff != '0); end
         3'd4: begin ncol = cc_ff - 1'b1; nvalid = (cc_ff != '0); end
         3'd5: begin nlay = cl_ff - 1'b1; nvalid = (cl_ff != '0); end
         default: nvalid = 1'b0;
      endcase
   end

   logic [DIST_W-1:0] nd;
   assign nd = (cd_ff == '1) ? cd_ff : cd_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      c_in = c_ff; r_in = r_ff; l_in = l_ff; ldone_in = ldone_ff;
      head_in = head_ff; tail_in = tail_ff;
      cc_in = cc_ff; cr_in = cr_ff; cl_in = cl_ff; cd_in = cd_ff;
      dir_in = dir_ff; na_in = na_ff;
      unr_in = unr_ff; best_in = best_ff;
      out_d_in = out_d_ff; out_u_in = out_u_ff;
      cell_we = 1'b0; cell_wa = {l_ff, r_ff, c_ff}; cell_wd = '0;
      cell_ra = {l_ff, r_ff, c_ff};
      q_we = 1'b0; q_wd = {l_ff, r_ff, c_ff};

      unique case (state_ff)
         ST_LOAD: begin
            if (req_tvalid) begin
               if (!ldone_ff) begin
                  cell_we = 1'b1;
                  cell_wd = {(req_tdata[1:0] != KIND_OPEN), {DIST_W{1'b0}}};
                  if (req_tdata[1:0] == KIND_SOURCE) begin
                     q_we = 1'b1;
                     tail_in = tail_ff + 1'b1;
                  end
               end
               // advance position
               if (!ldone_ff) begin
                  if (at_end) ldone_in = 1'b1;
                  else if (last_c) begin
                     c_in = '0;
                     if (last_r) begin r_in = '0; l_in = l_ff + 1'b1; end
                     else r_in = r_ff + 1'b1;
                  end else c_in = c_ff + 1'b1;
               end
               if (req_tlast) begin
                  state_in = (ldone_ff || at_end) ? ST_POP : ST_FILL;
                  if (!ldone_ff && !at_end) begin
                     c_in = c_ff; r_in = r_ff; l_in = l_ff;
                     // resume fill at next position
                     if (last_c) begin
                        c_in = '0;
                        if (last_r) begin r_in = '0; l_in = l_ff + 1'b1; end
                        else r_in = r_ff + 1'b1;
                     end else c_in = c_ff + 1'b1;
                  end
               end
            end
         end
         ST_FILL: begin
            cell_we = 1'b1;
            cell_wd = {1'b1, {DIST_W{1'b0}}};
            if (at_end) state_in = ST_POP;
            else if (last_c) begin
               c_in = '0;
               if (last_r) begin r_in = '0; l_in = l_ff + 1'b1; end
               else r_in = r_ff + 1'b1;
            end else c_in = c_ff + 1'b1;
         end
         ST_POP: begin
            // queue word at head_ff is read this cycle
            if (head_ff == tail_ff) begin
               state_in = ST_SCAN;
               c_in = '0; r_in = '0; l_in = '0;
               unr_in = 1'b0; best_in = '0; ldone_in = 1'b0;
            end else begin
               head_in = head_ff + 1'b1;
               state_in = ST_CUR;
            end
         end
         ST_CUR: begin
            {cl_in, cr_in, cc_in} = queue_rd_ff;
            cell_ra = queue_rd_ff;
            dir_in = '0;
            if ({1'b0, queue_rd_ff[AW-1:CW+RW]} >= nl ||
                {1'b0, queue_rd_ff[CW+RW-1:CW]} >= nr ||
                {1'b0, queue_rd_ff[CW-1:0]} >= nc)
               state_in = ST_POP;
            else
               state_in = ST_NBR;
         end
         ST_NBR: begin
            if (dir_ff == 3'd0) cd_in = cell_rd_ff[DIST_W-1:0];
            if (dir_ff == 3'd6) state_in = ST_POP;
            else if (nvalid) begin
               cell_ra = {nlay, nrow, ncol};
               na_in = {nlay, nrow, ncol};
               state_in = ST_CHK;
            end else dir_in = dir_ff + 1'b1;
         end
         ST_CHK: begin
            if (!cell_rd_ff[DIST_W]) begin
               cell_we = 1'b1;
               cell_wa = na_ff;
               cell_wd = {1'b1, nd};
               q_we = 1'b1;
               q_wd = na_ff;
               tail_in = tail_ff + 1'b1;
            end
            dir_in = dir_ff + 1'b1;
            state_in = ST_NBR;
         end
         ST_SCAN: begin
            // two phases: ldone_ff low issues read, high consumes it
            if (!ldone_ff) ldone_in = 1'b1;
            else begin
               ldone_in = 1'b0;
               if (!cell_rd_ff[DIST_W]) unr_in = 1'b1;
               else if (cell_rd_ff[DIST_W-1:0] > best_ff) best_in = cell_rd_ff[DIST_W-1:0];
               if (at_end) begin
                  state_in = ST_OUT;
                  out_u_in = unr_in;
                  out_d_in = unr_in ? 7'd0 :
                             (best_in > 8'd127) ? 7'd127 : best_in[6:0];
               end else if (last_c) begin
                  c_in = '0;
                  if (last_r) begin r_in = '0; l_in = l_ff + 1'b1; end
                  else r_in = r_ff + 1'b1;
               end else c_in = c_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_LOAD;
               c_in = '0; r_in = '0; l_in = '0; ldone_in = 1'b0;
               head_in = '0; tail_in = '0;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         c_ff <= '0; r_ff <= '0; l_ff <= '0; ldone_ff <= 1'b0;
         head_ff <= '0; tail_ff <= '0;
      end else begin
         state_ff <= state_in;
         c_ff <= c_in; r_ff <= r_in; l_ff <= l_in; ldone_ff <= ldone_in;
         head_ff <= head_in; tail_ff <= tail_in;
      end
      cc_ff <= cc_in; cr_ff <= cr_in; cl_ff <= cl_in; cd_ff <= cd_in;
      dir_ff <= dir_in; na_ff <= na_in;
      unr_ff <= unr_in; best_ff <= best_in;
      out_d_ff <= out_d_in; out_u_ff <= out_u_in;
   end
endmodule
`default_nettype wire

@@ hdl/g3b_checker.sv @@
// ----------------------------------------------------------------------------
// g3b_checker
// Port-level checks for the 3D grid multi-source BFS unit.
// ----------------------------------------------------------------------------
`default_nettype none
module g3b_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tuser
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while stalled");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready))
      else $error("input taken while result pending");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 8'd0)
      else $error("unreachable result carries a distance");
   a_rst: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result after reset");
endmodule

bind grid3d_multisource_bfs_days_unit g3b_checker u_g3b_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
);
`default_nettype wire
